@@ rtl/rcm_pkg.sv @@
// rcm_pkg: shared constants, types and the sine table function for the rainbow color map
// no dependencies; used by every file under rtl
package rcm_pkg;

   localparam int HEIGHT_BITS      = 16;
   localparam int FRACTION_BITS    = 10;
   localparam int CSR_BITS         = 16;
   localparam int COLOR_BITS       = 8;
   localparam int SCALE_RESET      = 768;

   localparam logic [COLOR_BITS-1:0] COLOR_MAX  = 8'd255;
   localparam logic [COLOR_BITS-1:0] COLOR_ZERO = 8'd0;

   // segment numbers taken from the top two quotient bits
   localparam logic [1:0] SEG_LOW  = 2'd0;
   localparam logic [1:0] SEG_MID  = 2'd1;
   localparam logic [1:0] SEG_HIGH = 2'd2;
   localparam logic [1:0] SEG_PAST = 2'd3;

   // control that rides along the divider chain
   typedef struct packed {
      logic valid;
      logic over;
   } cell_ctrl_type;

   // floor(255 * sin(pi/2 * idx / 2^fbits)), evaluated at elaboration only
   function automatic logic [COLOR_BITS-1:0] sine_entry(input int idx, input int fbits);
      real angle;
      int  value;
      if (idx <= 0) begin
         return COLOR_ZERO;
      end
      if (idx >= (1 << fbits)) begin
         return COLOR_MAX;
      end
      // quarter turn scaled by idx * 2^-fbits
      angle = 1.57079632679489661923 * real'(idx) * (2.0 ** real'(-fbits));
      value = $rtoi(255.0 * $sin(angle));
      return value[COLOR_BITS-1:0];
   endfunction

endpackage

@@ rtl/rcm_div_cell.sv @@
// rcm_div_cell: one restoring division step, one quotient bit per cell
// depends on rcm_pkg (cell_ctrl_type)
module rcm_div_cell #(
   parameter int HEIGHT_BITS   = rcm_pkg::HEIGHT_BITS,
   parameter int FRACTION_BITS = rcm_pkg::FRACTION_BITS,
   parameter bit CHECK_OVER    = 1'b0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic [HEIGHT_BITS-1:0]      divisor,
   input  rcm_pkg::cell_ctrl_type      in_ctrl,
   input  logic [HEIGHT_BITS-1:0]      in_num,
   input  logic [HEIGHT_BITS-1:0]      in_rem,
   input  logic [FRACTION_BITS+1:0]    in_quo,
   output rcm_pkg::cell_ctrl_type      out_ctrl,
   output logic [HEIGHT_BITS-1:0]      out_num,
   output logic [HEIGHT_BITS-1:0]      out_rem,
   output logic [FRACTION_BITS+1:0]    out_quo
);

   logic [HEIGHT_BITS:0]         trial;
   logic [HEIGHT_BITS:0]         diff;
   logic                         fits;

   rcm_pkg::cell_ctrl_type       ctrl_in,  ctrl_ff;
   logic [HEIGHT_BITS-1:0]       num_in,   num_ff;
   logic [HEIGHT_BITS-1:0]       rem_in,   rem_ff;
   logic [FRACTION_BITS+1:0]     quo_in,   quo_ff;

   // bring down the next dividend bit and try the subtraction
   assign trial = {in_rem, in_num[HEIGHT_BITS-1]};
   assign fits  = (trial >= {1'b0, divisor});
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      rem_in        = fits ? diff[HEIGHT_BITS-1:0] : trial[HEIGHT_BITS-1:0];
      num_in        = {in_num[HEIGHT_BITS-2:0], 1'b0};
      quo_in        = {in_quo[FRACTION_BITS:0], fits};
      ctrl_in.valid = in_ctrl.valid;
      // a set bit above the segment field means the height is past the scale
      ctrl_in.over  = in_ctrl.over | (CHECK_OVER & fits);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (enable) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign out_ctrl = ctrl_ff;
   assign out_num  = num_ff;
   assign out_rem  = rem_ff;
   assign out_quo  = quo_ff;

endmodule

@@ rtl/rcm_sine_rom.sv @@
// rcm_sine_rom: quarter-wave sine table with two registered read ports
// depends on rcm_pkg (sine_entry, COLOR_BITS)
module rcm_sine_rom #(
   parameter int FRACTION_BITS = rcm_pkg::FRACTION_BITS
) (
   input  logic                              clock,
   input  logic                              enable,
   input  logic [FRACTION_BITS:0]            sin_addr,
   input  logic [FRACTION_BITS:0]            cos_addr,
   output logic [rcm_pkg::COLOR_BITS-1:0]    sin_data,
   output logic [rcm_pkg::COLOR_BITS-1:0]    cos_data
);

   localparam int DEPTH = (1 << FRACTION_BITS) + 1;

   logic [rcm_pkg::COLOR_BITS-1:0] rom [DEPTH];
   logic [rcm_pkg::COLOR_BITS-1:0] sin_ff;
   logic [rcm_pkg::COLOR_BITS-1:0] cos_ff;

   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_entry
      localparam logic [rcm_pkg::COLOR_BITS-1:0] ENTRY =
         rcm_pkg::sine_entry(gi, FRACTION_BITS);
      assign rom[gi] = ENTRY;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sin_ff <= rom[sin_addr];
         cos_ff <= rom[cos_addr];
      end
   end

   assign sin_data = sin_ff;
   assign cos_data = cos_ff;

endmodule

@@ rtl/rainbow_color_map.sv @@
// rainbow_color_map: top level, maps a bar height to a rainbow rgb color
// depends on rcm_pkg, rcm_div_cell and rcm_sine_rom
//
// One height is taken per clock while req_tready is high and one rgb color comes out per height, in order.
// The full scale height (csr port) is split into three equal segments of width
// third = scale / 3; a height selects a segment and a position inside it,
// and a quarter-wave sine table blends the colors: red to green, green to blue,
// blue to red. Heights past the scale, and a scale below 3, give pure red.
// The height is divided by the third in a chain of HEIGHT_BITS + FRACTION_BITS
// division cells, one quotient bit per cell, so the quotient carries both the
// segment number and a FRACTION_BITS bit fraction. An accepted height loads the
// first cell and passes down the chain, then one table read and one output
// register lead to its color on rsp. Throughput is one transaction per cycle
// while rsp_tready is high.
// The output has a two-entry skid buffer and req_tready comes straight from a
// flop: it drops only when both entries hold results and the whole pipeline
// then holds still. The third is computed from csr_wdata and stored at the
// write edge; write the csr only while no transaction is in flight.
module rainbow_color_map #(
   parameter int HEIGHT_BITS   = rcm_pkg::HEIGHT_BITS,
   parameter int FRACTION_BITS = rcm_pkg::FRACTION_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((HEIGHT_BITS + 7) & ~7) - 1:0] req_tdata,  // height, zero padding
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [3 * rcm_pkg::COLOR_BITS - 1:0]  rsp_tdata,  // blue, green, red (red in the low byte)
   // configuration: full scale height
   input  logic                                  csr_wen,
   input  logic [rcm_pkg::CSR_BITS-1:0]          csr_wdata
);

   localparam int NUM_CELLS = HEIGHT_BITS + FRACTION_BITS;
   localparam int CB        = rcm_pkg::COLOR_BITS;

   // ceil(2^(HEIGHT_BITS+1) / 3): exact divide by three for any HEIGHT_BITS value
   localparam logic [HEIGHT_BITS:0] DIV3_RECIP =
      (HEIGHT_BITS + 1)'(((64'd1 << (HEIGHT_BITS + 1)) + 64'd2) / 64'd3);
   localparam logic [HEIGHT_BITS-1:0] MAX_RESET   = HEIGHT_BITS'(rcm_pkg::SCALE_RESET);
   localparam logic [HEIGHT_BITS-1:0] THIRD_RESET = HEIGHT_BITS'(MAX_RESET / 3);
   localparam logic [FRACTION_BITS:0] ROM_FULL    = {1'b1, {FRACTION_BITS{1'b0}}};

   // ---------------------------------------------------------------- csr
   logic [HEIGHT_BITS-1:0]   csr_height;
   logic [2*HEIGHT_BITS:0]   third_prod;
   logic [HEIGHT_BITS-1:0]   third_in, third_ff;

   assign csr_height = HEIGHT_BITS'(csr_wdata);
   assign third_prod = {{(HEIGHT_BITS + 1){1'b0}}, csr_height}
                     * {{HEIGHT_BITS{1'b0}}, DIV3_RECIP};
   assign third_in   = third_prod[2*HEIGHT_BITS:HEIGHT_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         third_ff <= THIRD_RESET;
      end else if (csr_wen) begin
         third_ff <= third_in;
      end
   end

   // ---------------------------------------------------------------- flow control
   logic adv;          // whole pipeline moves one step
   logic skid_valid_ff;

   assign adv        = ~skid_valid_ff;
   assign req_tready = adv;

   // ---------------------------------------------------------------- divider chain
   rcm_pkg::cell_ctrl_type     chain_ctrl [NUM_CELLS+1];
   logic [HEIGHT_BITS-1:0]     chain_num  [NUM_CELLS+1];
   logic [HEIGHT_BITS-1:0]     chain_rem  [NUM_CELLS+1];
   logic [FRACTION_BITS+1:0]   chain_quo  [NUM_CELLS+1];

   // the dividend is height << FRACTION_BITS; the low zeros shift in behind it
   always_comb begin
      chain_ctrl[0].valid = req_tvalid;
      chain_ctrl[0].over  = 1'b0;
      chain_num[0]        = req_tdata[HEIGHT_BITS-1:0];
      chain_rem[0]        = '0;
      chain_quo[0]        = '0;
   end

   for (genvar gj = 0; gj < NUM_CELLS; gj++) begin : g_cell
      // cells above the two segment bits only flag an out-of-scale height
      rcm_div_cell #(
         .HEIGHT_BITS   (HEIGHT_BITS),
         .FRACTION_BITS (FRACTION_BITS),
         .CHECK_OVER    (gj < HEIGHT_BITS - 2)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (adv),
         .divisor  (third_ff),
         .in_ctrl  (chain_ctrl[gj]),
         .in_num   (chain_num[gj]),
         .in_rem   (chain_rem[gj]),
         .in_quo   (chain_quo[gj]),
         .out_ctrl (chain_ctrl[gj+1]),
         .out_num  (chain_num[gj+1]),
         .out_rem  (chain_rem[gj+1]),
         .out_quo  (chain_quo[gj+1])
      );
   end

   // ---------------------------------------------------------------- table stage
   logic [1:0]                 last_seg;
   logic [FRACTION_BITS-1:0]   last_frac;
   logic                       last_red;
   logic [FRACTION_BITS:0]     sin_addr, cos_addr;
   logic [CB-1:0]              sin_data, cos_data;

   logic                       map_valid_ff;
   logic                       map_red_ff;
   logic [1:0]                 map_seg_ff;

   assign last_seg  = chain_quo[NUM_CELLS][FRACTION_BITS+1:FRACTION_BITS];
   assign last_frac = chain_quo[NUM_CELLS][FRACTION_BITS-1:0];
   assign last_red  = chain_ctrl[NUM_CELLS].over
                    | (last_seg == rcm_pkg::SEG_PAST)
                    | (third_ff == '0);
   assign sin_addr  = {1'b0, last_frac};
   assign cos_addr  = ROM_FULL - {1'b0, last_frac};

   rcm_sine_rom #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_rom (
      .clock    (clock),
      .enable   (adv),
      .sin_addr (sin_addr),
      .cos_addr (cos_addr),
      .sin_data (sin_data),
      .cos_data (cos_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= 1'b0;
      end else if (adv) begin
         map_valid_ff <= chain_ctrl[NUM_CELLS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         map_red_ff <= last_red;
         map_seg_ff <= last_seg;
      end
   end

   // ---------------------------------------------------------------- color select
   logic [CB-1:0]   red, green, blue;
   logic [3*CB-1:0] color;

   always_comb begin
      red   = rcm_pkg::COLOR_MAX;
      green = rcm_pkg::COLOR_ZERO;
      blue  = rcm_pkg::COLOR_ZERO;
      if (!map_red_ff) begin
         case (map_seg_ff)
            rcm_pkg::SEG_LOW: begin
               red   = cos_data;
               green = sin_data;
               blue  = rcm_pkg::COLOR_ZERO;
            end
            rcm_pkg::SEG_MID: begin
               red   = rcm_pkg::COLOR_ZERO;
               green = cos_data;
               blue  = sin_data;
            end
            rcm_pkg::SEG_HIGH: begin
               red   = sin_data;
               green = rcm_pkg::COLOR_ZERO;
               blue  = cos_data;
            end
            default: begin
               red   = rcm_pkg::COLOR_MAX;
               green = rcm_pkg::COLOR_ZERO;
               blue  = rcm_pkg::COLOR_ZERO;
            end
         endcase
      end
   end

   assign color = {blue, green, red};

   // ---------------------------------------------------------------- output skid buffer
   logic            push, pop;
   logic            rsp_valid_ff;
   logic [3*CB-1:0] rsp_data_ff;
   logic [3*CB-1:0] skid_data_ff;

   assign push = map_valid_ff & adv;
   assign pop  = rsp_valid_ff & rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || pop) begin
         // output slot frees up: skid entry moves first, new color behind it
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= push;
         end else begin
            rsp_valid_ff  <= push;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_data_ff <= skid_data_ff;
            if (push) begin
               skid_data_ff <= color;
            end
         end else if (push) begin
            rsp_data_ff <= color;
         end
      end else if (push) begin
         skid_data_ff <= color;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/rcm_checker.sv @@
// rcm_checker: port-level assertions for rainbow_color_map, attached by bind
// depends on rcm_pkg (COLOR_BITS) and the rainbow_color_map port list
module rcm_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tready,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [3 * rcm_pkg::COLOR_BITS - 1:0]  rsp_tdata
);

   localparam int CB = rcm_pkg::COLOR_BITS;

   // a stalled result transaction keeps its color
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // input side only backs up once a result is waiting on the output
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req_tready low with no result waiting");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   // every rainbow color has at least one dark channel
   a_one_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[CB-1:0] == '0) || (rsp_tdata[2*CB-1:CB] == '0)
                  || (rsp_tdata[3*CB-1:2*CB] == '0))
      else $error("color with all three channels lit");

   // a full output buffer with no drain keeps the input closed
   a_stall_closed: assert property (@(posedge clock) disable iff (reset)
      !req_tready && !rsp_tready |=> !req_tready)
      else $error("req_tready rose while output stayed stalled");

endmodule

bind rainbow_color_map rcm_checker u_rcm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
